@@ rtl/epm_pkg.sv @@
package epm_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned OUT_IDX_W = 7;
  localparam int unsigned ROT_W   = 5;
  localparam int unsigned TAP_W   = 3;
  localparam int unsigned TAP_LAST = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_STEP = 16'd4;
  localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_MAX - COUNT_STEP;

  localparam logic [ROT_W-1:0] ROT_STEP      = 5'd7;
  localparam logic [ROT_W-1:0] ROT_STEP_WRAP = 5'd14;

  localparam logic [0:0] CFG_MIN_RESEED = 1'b0;
  localparam logic [0:0] CFG_MAX_RESEED = 1'b1;

  typedef enum logic [1:0] {
    KIND_MIX   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [WORD_W-1:0]   entropy_word;
    logic [OUT_IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] pool_index;
    logic [WORD_W-1:0]    pool_word;
    logic [COUNT_W-1:0]   entropy_bytes;
    logic                 reseed_ready;
    logic                 reseed_due;
  } result_t;

  // CRC-32 derived twist words
  function automatic logic [WORD_W-1:0] twist(input logic [2:0] sel);
    logic [WORD_W-1:0] t;
    unique case (sel)
      3'd0: t = 32'h00000000;
      3'd1: t = 32'h3b6e20c8;
      3'd2: t = 32'h76dc4190;
      3'd3: t = 32'h4db26158;
      3'd4: t = 32'hedb88320;
      3'd5: t = 32'hd6d6a3e8;
      3'd6: t = 32'h9b64c2b0;
      3'd7: t = 32'ha00ae278;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // Tap offsets from the write pointer, in read order
  function automatic logic [6:0] tap_off(input logic [TAP_W-1:0] tap);
    logic [6:0] o;
    unique case (tap)
      3'd0: o = 7'd0;
      3'd1: o = 7'd1;
      3'd2: o = 7'd25;
      3'd3: o = 7'd51;
      3'd4: o = 7'd76;
      3'd5: o = 7'd104;
      default: o = 7'd0;
    endcase
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [ROT_W-1:0] r);
    logic [5:0] rc;
    rc = 6'd32 - {1'b0, r};
    return (x << r) | (x >> rc);
  endfunction

endpackage

@@ rtl/epm_pool_ram.sv @@
module epm_pool_ram
  import epm_pkg::*;
#(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // single port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/epm_mix_core.sv @@
module epm_mix_core
  import epm_pkg::*;
#(
  parameter int unsigned POOL_WORDS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  item_t              item,
  output logic               item_pop,
  input  logic               res_ready,
  output logic               res_push,
  output result_t            res,
  input  logic [COUNT_W-1:0] min_thr,
  input  logic [COUNT_W-1:0] max_thr,
  output logic               clearing
);

  localparam int unsigned IDX_W = $clog2(POOL_WORDS);

  state_t             state, state_next;
  logic [IDX_W-1:0]   ptr;
  logic [ROT_W-1:0]   rot;
  logic [COUNT_W-1:0] count;
  logic [1:0]         kind_q;
  logic [IDX_W-1:0]   idx_q;
  logic [WORD_W-1:0]  acc;
  logic [TAP_W-1:0]   tap;
  logic [IDX_W-1:0]   clr_addr;

  logic               mem_en, mem_we;
  logic [IDX_W-1:0]   mem_addr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  logic [IDX_W-1:0]   ptr_dec;
  logic [WORD_W-1:0]  mix_w, mix_val;
  logic [COUNT_W-1:0] count_next;

  epm_pool_ram #(
    .DEPTH  (POOL_WORDS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign ptr_dec  = ptr - 1'b1;
  assign mix_w    = acc ^ mem_rdata;
  assign mix_val  = (mix_w >> 3) ^ twist(mix_w[2:0]);
  assign clearing = (state == S_CLEAR);

  always_comb begin
    case (kind_q)
      KIND_MIX:   count_next = (count >= COUNT_SAT) ? COUNT_MAX : count + COUNT_STEP;
      KIND_CLEAR: count_next = '0;
      default:    count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    res_push   = 1'b0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = idx_q;
    mem_wdata  = '0;
    res        = '0;
    unique case (state)
      S_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr;
        if (&clr_addr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.kind == KIND_MIX) begin
            mem_en     = 1'b1;
            mem_addr   = ptr_dec;
            state_next = S_READ;
          end else if (item.kind == KIND_READ) begin
            mem_en     = 1'b1;
            mem_addr   = IDX_W'(item.read_index);
            state_next = S_DONE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        mem_en   = 1'b1;
        mem_addr = ptr + IDX_W'(tap_off(tap));
        if (tap == TAP_W'(TAP_LAST)) state_next = S_DONE;
      end
      S_DONE: begin
        res.entropy_bytes = count_next;
        res.reseed_ready  = (count_next >= min_thr);
        res.reseed_due    = (count_next >= max_thr);
        if (kind_q == KIND_MIX) begin
          res.pool_index = idx_q[OUT_IDX_W-1:0];
          res.pool_word  = mix_val;
        end else if (kind_q == KIND_READ) begin
          res.pool_index = idx_q[OUT_IDX_W-1:0];
          res.pool_word  = mem_rdata;
        end
        if (res_ready) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
          if (kind_q == KIND_MIX) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = mix_val;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rot      <= '0;
      count    <= '0;
      clr_addr <= '0;
      tap      <= '0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_IDLE && item_valid && item.kind == KIND_MIX) begin
        ptr <= ptr_dec;
        rot <= rot + ((ptr_dec != '0) ? ROT_STEP : ROT_STEP_WRAP);
        tap <= TAP_W'(1);
      end else if (state == S_READ) begin
        tap <= tap + 1'b1;
      end
      if (res_push) count <= count_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      kind_q <= item.kind;
      if (item.kind == KIND_MIX) begin
        idx_q <= ptr_dec;
        acc   <= rotl(item.entropy_word, rot);
      end else begin
        idx_q <= IDX_W'(item.read_index);
      end
    end else if (state == S_READ) begin
      acc <= acc ^ mem_rdata;
    end
  end

endmodule

@@ rtl/entropy_pool_mixer.sv @@
// Entropy pool mixer.
// Input channel (in_valid/in_ready) carries one request: kind selects mix
// (entropy_word is rotated, folded with six pool taps, twisted and written
// back), read (pool entry read_index is returned) or clear (new-entropy byte
// count drops to zero). Output channel (out_valid/out_ready) returns exactly
// one result per request: the pool entry touched, its word, the byte count
// and the reseed_ready/reseed_due flags against the two threshold registers.
// cfg_write/cfg_index/cfg_data write the thresholds; write only while idle.
// Timing: a request lands in a one-entry input buffer, so the next request is
// taken while one is in progress. A mix holds the single pool memory port for
// six tap reads and one write back before the core takes its next request;
// read, clear and unused kinds go from idle straight to the result. out_valid
// is registered and rises once the result is loaded into the output register.
// Reset: a clearing pass zeroes the pool, one entry a cycle; in_ready stays
// low during it while config writes are still taken.
// Receiver stall: the output register holds its result; the core then holds
// its finished request, and the input buffer fills and drops in_ready.
module entropy_pool_mixer
  import epm_pkg::*;
#(
  parameter int unsigned POOL_WORDS = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [WORD_W-1:0]    entropy_word,
  input  logic [OUT_IDX_W-1:0] read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] pool_index,
  output logic [WORD_W-1:0]    pool_word,
  output logic [COUNT_W-1:0]   entropy_bytes,
  output logic                 reseed_ready,
  output logic                 reseed_due,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  logic               ibuf_valid;
  item_t              ibuf;
  logic               item_pop;
  logic               res_push, res_ready;
  result_t            res;
  logic               clearing;
  logic [COUNT_W-1:0] min_reseed_bytes;
  logic [COUNT_W-1:0] max_reseed_bytes;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_reseed_bytes <= 16'd128;
      max_reseed_bytes <= 16'd1024;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MIN_RESEED: min_reseed_bytes <= cfg_data;
        CFG_MAX_RESEED: max_reseed_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input buffer: take a request whenever the slot is empty and the pool is not clearing
  assign in_ready = !ibuf_valid && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ibuf_valid <= 1'b1;
    end else if (item_pop) begin
      ibuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibuf.kind         <= kind;
      ibuf.entropy_word <= entropy_word;
      ibuf.read_index   <= read_index;
    end
  end

  epm_mix_core #(
    .POOL_WORDS (POOL_WORDS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (ibuf_valid),
    .item       (ibuf),
    .item_pop   (item_pop),
    .res_ready  (res_ready),
    .res_push   (res_push),
    .res        (res),
    .min_thr    (min_reseed_bytes),
    .max_thr    (max_reseed_bytes),
    .clearing   (clearing)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      pool_index    <= res.pool_index;
      pool_word     <= res.pool_word;
      entropy_bytes <= res.entropy_bytes;
      reseed_ready  <= res.reseed_ready;
      reseed_due    <= res.reseed_due;
    end
  end

endmodule
